[rtl/orlt_pkg.sv]
package orlt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int ADDR_W  = 32;
    localparam int POS_W   = 4;
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;
    localparam int WIDE_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 40;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_PROTECTED = 2'd2;
    localparam logic [ST_W-1:0] ST_MISS      = 2'd3;

    localparam logic [ADDR_W-1:0] MISS_HOP = {ADDR_W{1'b1}};

    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

endpackage

[rtl/orlt_dp.sv]
module orlt_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  orlt_pkg::dp_cmd_t             cmd,
    input  logic [orlt_pkg::OP_W-1:0]     op,
    input  logic [orlt_pkg::ADDR_W-1:0]   route_mask,
    input  logic [orlt_pkg::ADDR_W-1:0]   route_net,
    input  logic [orlt_pkg::ADDR_W-1:0]   route_next_hop,
    input  logic                          is_direct,
    input  logic [orlt_pkg::POS_W-1:0]    entry_position,
    input  logic [orlt_pkg::ADDR_W-1:0]   lookup_address,
    output logic [orlt_pkg::ST_W-1:0]     status,
    output logic [orlt_pkg::ADDR_W-1:0]   next_hop,
    output logic [orlt_pkg::POS_W-1:0]    placed_at
);

    logic [orlt_pkg::ADDR_W-1:0] mask_reg [orlt_pkg::ENTRIES];
    logic [orlt_pkg::ADDR_W-1:0] net_reg  [orlt_pkg::ENTRIES];
    logic [orlt_pkg::ADDR_W-1:0] hop_reg  [orlt_pkg::ENTRIES];
    logic                        dir_reg  [orlt_pkg::ENTRIES];
    logic [orlt_pkg::CNT_W-1:0]  count_reg;
    logic [orlt_pkg::CNT_W-1:0]  count_next;

    logic [orlt_pkg::OP_W-1:0]   it_op_reg;
    logic [orlt_pkg::ADDR_W-1:0] it_mask_reg;
    logic [orlt_pkg::ADDR_W-1:0] it_net_reg;
    logic [orlt_pkg::ADDR_W-1:0] it_hop_reg;
    logic                        it_dir_reg;
    logic [orlt_pkg::POS_W-1:0]  it_pos_reg;
    logic [orlt_pkg::ENTRIES-1:0] flag_reg;
    logic [orlt_pkg::ENTRIES-1:0] flag_next;

    logic [orlt_pkg::ST_W-1:0]   status_reg;
    logic [orlt_pkg::ST_W-1:0]   status_next;
    logic [orlt_pkg::ADDR_W-1:0] hop_out_reg;
    logic [orlt_pkg::ADDR_W-1:0] hop_out_next;
    logic [orlt_pkg::POS_W-1:0]  placed_reg;
    logic [orlt_pkg::POS_W-1:0]  placed_next;

    logic [orlt_pkg::IDX_W-1:0]  enc_idx;
    logic                        enc_found;
    logic [orlt_pkg::IDX_W-1:0]  ins_idx;
    logic [orlt_pkg::IDX_W-1:0]  pos_idx;
    logic [orlt_pkg::IDX_W-1:0]  sel_idx;
    logic [orlt_pkg::WIDE_W-1:0] pos_ext;
    logic [orlt_pkg::WIDE_W-1:0] ins_ext;
    logic                        pos_bad;
    logic                        table_full;
    logic                        sel_dir;
    logic [orlt_pkg::ADDR_W-1:0] sel_hop;
    logic                        do_ins;
    logic                        do_rem;

    function automatic logic [orlt_pkg::IDX_W-1:0] first_set(
        input logic [orlt_pkg::ENTRIES-1:0] v
    );
        logic [orlt_pkg::IDX_W-1:0] r;
        r = '0;
        for (int i = orlt_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = orlt_pkg::IDX_W'(i);
            end
        end
        return r;
    endfunction

    // insert: stop bit where the new route goes; lookup: hit bit
    always_comb
    begin
        for (int i = 0; i < orlt_pkg::ENTRIES; i++)
        begin
            if (op == orlt_pkg::OP_LOOKUP)
            begin
                flag_next[i] = (orlt_pkg::CNT_W'(i) < count_reg) &&
                               ((lookup_address & mask_reg[i]) == net_reg[i]);
            end
            else
            begin
                flag_next[i] = !(orlt_pkg::CNT_W'(i) < count_reg) ||
                               !(dir_reg[i] || (mask_reg[i] > route_mask));
            end
        end
    end

    always_comb
    begin
        enc_idx    = first_set(flag_reg);
        enc_found  = |flag_reg;
        ins_idx    = it_dir_reg ? '0 : enc_idx;
        ins_ext    = orlt_pkg::WIDE_W'(ins_idx);
        pos_ext    = orlt_pkg::WIDE_W'(it_pos_reg);
        pos_idx    = pos_ext[orlt_pkg::IDX_W-1:0];
        pos_bad    = pos_ext >= orlt_pkg::WIDE_W'(count_reg);
        table_full = count_reg == orlt_pkg::CNT_W'(orlt_pkg::ENTRIES);
        sel_idx    = (it_op_reg == orlt_pkg::OP_LOOKUP) ? enc_idx : pos_idx;
        sel_dir    = dir_reg[sel_idx];
        sel_hop    = hop_reg[sel_idx];

        status_next  = orlt_pkg::ST_MISS;
        hop_out_next = '0;
        placed_next  = '0;
        do_ins       = 1'b0;
        do_rem       = 1'b0;
        case (it_op_reg)
            orlt_pkg::OP_INSERT:
            begin
                if (table_full)
                begin
                    status_next = orlt_pkg::ST_FULL;
                end
                else
                begin
                    status_next = orlt_pkg::ST_OK;
                    placed_next = ins_ext[orlt_pkg::POS_W-1:0];
                    do_ins      = cmd.commit;
                end
            end
            orlt_pkg::OP_REMOVE:
            begin
                if (pos_bad)
                begin
                    status_next = orlt_pkg::ST_MISS;
                end
                else if (sel_dir)
                begin
                    status_next = orlt_pkg::ST_PROTECTED;
                end
                else
                begin
                    status_next = orlt_pkg::ST_OK;
                    do_rem      = cmd.commit;
                end
            end
            orlt_pkg::OP_LOOKUP:
            begin
                if (enc_found)
                begin
                    status_next  = orlt_pkg::ST_OK;
                    hop_out_next = sel_dir ? '0 : sel_hop;
                end
                else
                begin
                    status_next  = orlt_pkg::ST_MISS;
                    hop_out_next = orlt_pkg::MISS_HOP;
                end
            end
            default:
            begin
                status_next = orlt_pkg::ST_MISS;
            end
        endcase

        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + orlt_pkg::CNT_W'(1);
        end
        else if (do_rem)
        begin
            count_next = count_reg - orlt_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            it_op_reg   <= op;
            it_mask_reg <= route_mask;
            it_net_reg  <= route_net;
            it_hop_reg  <= route_next_hop;
            it_dir_reg  <= is_direct;
            it_pos_reg  <= entry_position;
            flag_reg    <= flag_next;
        end
        if (cmd.commit)
        begin
            status_reg  <= status_next;
            hop_out_reg <= hop_out_next;
            placed_reg  <= placed_next;
        end
        if (do_ins)
        begin
            for (int i = 0; i < orlt_pkg::ENTRIES; i++)
            begin
                if (orlt_pkg::IDX_W'(i) == ins_idx)
                begin
                    mask_reg[i] <= it_mask_reg;
                    net_reg[i]  <= it_net_reg;
                    hop_reg[i]  <= it_hop_reg;
                    dir_reg[i]  <= it_dir_reg;
                end
            end
            for (int i = 1; i < orlt_pkg::ENTRIES; i++)
            begin
                if (orlt_pkg::IDX_W'(i) > ins_idx)
                begin
                    mask_reg[i] <= mask_reg[i-1];
                    net_reg[i]  <= net_reg[i-1];
                    hop_reg[i]  <= hop_reg[i-1];
                    dir_reg[i]  <= dir_reg[i-1];
                end
            end
        end
        if (do_rem)
        begin
            for (int i = 0; i < orlt_pkg::ENTRIES - 1; i++)
            begin
                if (orlt_pkg::IDX_W'(i) >= pos_idx)
                begin
                    mask_reg[i] <= mask_reg[i+1];
                    net_reg[i]  <= net_reg[i+1];
                    hop_reg[i]  <= hop_reg[i+1];
                    dir_reg[i]  <= dir_reg[i+1];
                end
            end
        end
    end

    assign status    = status_reg;
    assign next_hop  = hop_out_reg;
    assign placed_at = placed_reg;

endmodule

[rtl/orlt_ctrl.sv]
module orlt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output orlt_pkg::dp_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        s_tready    = (state_reg == S_IDLE);
        cmd.capture = s_tvalid && s_tready;
        cmd.commit  = (state_reg == S_APPLY) && (!out_valid_reg || m_tready);

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_capture_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !s_tready && (state_reg == S_APPLY))
        else $error("input taken while an item is in work");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid && s_tready)
        else $error("committed item not presented");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.commit))
        else $error("result without commit");

endmodule

[rtl/ordered_route_table_lookup.sv]
// Channel  Dir  Handshake            Payload
// s        in   s_tvalid / s_tready  s_tuser op, s_tdata route and lookup fields
// m        out  m_tvalid / m_tready  m_tuser status, m_tdata next hop and position
//
// Capture takes an item and evaluates all 16 entries in parallel; commit picks the first
// flagged entry (slot 0 if direct insert, entry_position on remove) and updates the table.
// One item is in work at a time; the next is taken once the previous commits.
// The result register holds a finished item while m_tready is low; commit waits for it.
// Reset clears the route count and the handshake state; entries need no clearing.
module ordered_route_table_lookup
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [orlt_pkg::OP_W-1:0]         s_tuser,  // op
    // route_mask, route_net, route_next_hop, is_direct, entry_position, lookup_address
    input  logic [orlt_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [orlt_pkg::ST_W-1:0]         m_tuser,  // status
    output logic [orlt_pkg::OUT_DATA_W-1:0]   m_tdata   // next_hop, placed_at
);

    orlt_pkg::dp_cmd_t               cmd;
    logic [orlt_pkg::ADDR_W-1:0]     next_hop;
    logic [orlt_pkg::POS_W-1:0]      placed_at;

    orlt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    orlt_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .op             (s_tuser),
        .route_mask     (s_tdata[31:0]),
        .route_net      (s_tdata[63:32]),
        .route_next_hop (s_tdata[95:64]),
        .is_direct      (s_tdata[96]),
        .entry_position (s_tdata[100:97]),
        .lookup_address (s_tdata[132:101]),
        .status         (m_tuser),
        .next_hop       (next_hop),
        .placed_at      (placed_at)
    );

    assign m_tdata = {4'b0000, placed_at, next_hop};

endmodule
